### sv/ovl_pkg.sv
// types and codes shared by the ordered value list
// no dependencies; compile first
package ovl_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;
    localparam logic [1:0] OP_IDLE   = 2'd3;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic               found;
        logic               full_error;
        logic [COUNT_W-1:0] count;
    } rsp_t;

    // broadcast to every cell while a request walks the chain
    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
    } ctrl_t;

    // handed from one cell to the next each cycle
    typedef struct packed {
        logic                      active;
        logic                      matched;
        logic signed [VALUE_W-1:0] carry;
    } link_t;

endpackage

### sv/ovl_cell.sv
// one list position: holds an entry and acts when the token passes
// depends on ovl_pkg
module ovl_cell #(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ovl_pkg::ctrl_t                    ctrl,
    input  logic [CW-1:0]                     count,
    input  ovl_pkg::link_t                    link_in,
    input  logic signed [ovl_pkg::VALUE_W-1:0] next_value,
    output ovl_pkg::link_t                    link_out,
    output logic signed [ovl_pkg::VALUE_W-1:0] value
);
    import ovl_pkg::*;

    localparam logic [CW-1:0] POS = CW'(IDX);

    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic signed [VALUE_W-1:0] carry_reg, carry_next;
    logic                      active_reg, active_next;
    logic                      matched_reg, matched_next;
    logic                      occupied;
    logic                      in_reach;
    logic                      hit;

    assign occupied = POS < count;
    assign in_reach = POS <= count;
    assign hit      = occupied && !link_in.matched && (value_reg == ctrl.value);

    always_comb
    begin
        value_next   = value_reg;
        carry_next   = link_in.carry;
        active_next  = link_in.active;
        matched_next = link_in.matched;
        if (link_in.active)
        begin
            unique case (ctrl.op)
                OP_INSERT:
                begin
                    // take the value from the front side, pass ours on
                    if (in_reach)
                    begin
                        value_next = link_in.carry;
                        carry_next = value_reg;
                    end
                end
                OP_REMOVE:
                begin
                    matched_next = link_in.matched || hit;
                    // close the gap once the match is at or ahead of us
                    if (occupied && (link_in.matched || hit))
                        value_next = next_value;
                end
                OP_SEARCH:
                    matched_next = link_in.matched || hit;
                OP_IDLE:
                    matched_next = link_in.matched;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            matched_reg <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            matched_reg <= matched_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        carry_reg <= carry_next;
    end

    assign link_out.active  = active_reg;
    assign link_out.matched = matched_reg;
    assign link_out.carry   = carry_reg;
    assign value            = value_reg;

endmodule

### sv/ordered_value_list_unit.sv
// channel | direction | payload | handshake
// req     | in        | req_t   | req_valid / req_ready
// rsp     | out       | rsp_t   | rsp_valid / rsp_ready
//
// one request at a time: the response is built once the token has walked the row of cells
// one position per cycle, then passed from the hold state into the rsp slot
// reset clears the entry count, the state and the start and valid flags; entries need no clearing
// a response held by rsp_ready low keeps the next request waiting for rsp slot
// depends on ovl_pkg and ovl_cell
module ordered_value_list_unit #(
    parameter int DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ovl_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ovl_pkg::rsp_t rsp
);
    import ovl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_HOLD  = 2'd2;

    logic [1:0]    state_reg, state_next;
    ctrl_t         ctrl_reg, ctrl_next;
    logic [CW-1:0] count_reg, count_next;
    logic          start_reg, start_next;
    logic          full_reg, full_next;
    rsp_t          pend_reg, pend_next;
    logic          rsp_valid_reg, rsp_valid_next;
    rsp_t          rsp_reg, rsp_next;

    logic [CW-1:0]   new_count;
    logic [CW+4:0]   count_ext;
    logic            accept;
    logic            tail_found;

    link_t                     links [DEPTH+1];
    logic signed [VALUE_W-1:0] vals  [DEPTH+1];

    assign links[0].active  = start_reg;
    assign links[0].matched = 1'b0;
    assign links[0].carry   = ctrl_reg.value;
    assign vals[DEPTH]      = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        ovl_cell #(
            .CW (CW),
            .IDX(i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl_reg),
            .count     (count_reg),
            .link_in   (links[i]),
            .next_value(vals[i+1]),
            .link_out  (links[i+1]),
            .value     (vals[i])
        );
    end

    assign accept     = req_valid && req_ready;
    assign tail_found = links[DEPTH].matched;

    always_comb
    begin
        new_count = count_reg;
        if (ctrl_reg.op == OP_INSERT)
            new_count = count_reg + CW'(1);
        else if (ctrl_reg.op == OP_REMOVE && tail_found)
            new_count = count_reg - CW'(1);
    end

    assign count_ext = {5'b0, new_count};

    always_comb
    begin
        state_next     = state_reg;
        ctrl_next      = ctrl_reg;
        count_next     = count_reg;
        start_next     = 1'b0;
        full_next      = full_reg;
        pend_next      = pend_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl_next.value = req.value;
                    ctrl_next.op    = req.operation;
                    full_next       = 1'b0;
                    if (req.operation == OP_INSERT && count_reg == CW'(DEPTH))
                    begin
                        // dropped insert still walks the chain as a no-op
                        ctrl_next.op = OP_IDLE;
                        full_next    = 1'b1;
                    end
                    start_next = 1'b1;
                    state_next = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                if (links[DEPTH].active)
                begin
                    count_next           = new_count;
                    pend_next.found      = tail_found;
                    pend_next.full_error = full_reg;
                    pend_next.count      = count_ext[COUNT_W-1:0];
                    state_next           = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            start_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            start_reg     <= start_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ctrl_reg <= ctrl_next;
        full_reg <= full_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### sv/ovl_checker.sv
// port-level checks for the ordered value list, bound to the top level
// depends on ovl_pkg and ordered_value_list_unit
module ovl_checker #(
    parameter int DEPTH = 16
) (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input ovl_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input ovl_pkg::rsp_t rsp
);
    import ovl_pkg::*;

    // one request in flight: no second acceptance right behind the first
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in flight");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.found && rsp.full_error))
        else $error("found and full_error both set");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (DEPTH > 31) || (int'(rsp.count) <= DEPTH))
        else $error("count beyond capacity");

endmodule

bind ordered_value_list_unit ovl_checker #(.DEPTH(DEPTH)) u_ovl_checker (.*);

### sim/ordered_value_list_unit_test.sv
// self-checking testbench for ordered_value_list_unit: directed table, then random requests
// depends on ovl_pkg and the unit with its cells; needs nothing else
`timescale 1ns / 1ps

module ordered_value_list_unit_test;

    import ovl_pkg::*;

    localparam int LIST_DEPTH     = 16;
    localparam int LIST_LATENCY   = LIST_DEPTH + 3;
    localparam int TOTAL_REQUESTS = 800;
    localparam int STALL_LIMIT    = 5000;
    localparam int DIR_ROWS       = 28;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] value;
        logic                      typed;
        rsp_t                      want;
    } dir_row_t;

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_ready;
    req_t  req       = '0;
    logic  rsp_valid;
    logic  rsp_ready = 1'b0;
    rsp_t  rsp;

    // list contents as the unit should hold them, front first
    logic signed [VALUE_W-1:0] list_model [$];
    rsp_t                      pending_rsp_q [$];
    rsp_t                      oldest_rsp;
    dir_row_t                  dir_rows [DIR_ROWS];
    int                        fault_count    = 0;
    int                        quiet_cycles   = 0;
    int unsigned               send_idle_pct  = 7;
    int unsigned               recv_stall_pct = 63;

    ordered_value_list_unit #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // applies one request to the list copy and returns the response it should give
    function automatic rsp_t apply_list_op(input req_t r);
        rsp_t res;
        int   hit;
        res = '0;
        hit = -1;
        if (r.operation == OP_REMOVE || r.operation == OP_SEARCH)
        begin
            foreach (list_model[i])
            begin
                if (hit < 0 && list_model[i] == r.value)
                    hit = i;
            end
        end
        case (r.operation)
            OP_INSERT:
            begin
                if (list_model.size() >= LIST_DEPTH)
                    res.full_error = 1'b1;
                else
                    list_model.push_front(r.value);
            end
            OP_REMOVE:
            begin
                if (hit >= 0)
                begin
                    res.found = 1'b1;
                    list_model.delete(hit);
                end
            end
            OP_SEARCH:
                res.found = (hit >= 0);
            default:
                ;
        endcase
        res.count = COUNT_W'(list_model.size());
        return res;
    endfunction

    function automatic logic [1:0] pick_operation(input bit filling);
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return OP_IDLE;
        if (filling)
            return (sel < 60) ? OP_INSERT : (sel < 82) ? OP_REMOVE : OP_SEARCH;
        return (sel < 25) ? OP_INSERT : (sel < 72) ? OP_REMOVE : OP_SEARCH;
    endfunction

    // mostly values already held or from a small pool, so removes and searches hit
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40)
        begin
            case ($urandom_range(7))
                0: return 32'sd0;
                1: return 32'sd1;
                2: return -32'sd1;
                3: return VAL_MIN;
                4: return VAL_MAX;
                5: return 32'sd42;
                6: return 32'sh5555_5555;
                default: return 32'shAAAA_AAAA;
            endcase
        end
        if (sel < 75 && list_model.size() != 0)
            return list_model[$urandom_range(list_model.size() - 1)];
        return $urandom;
    endfunction

    task automatic send_req(input req_t r, input logic typed, input rsp_t want);
        rsp_t predicted;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted = apply_list_op(r);
        pending_rsp_q.push_back(typed ? want : predicted);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp_q.size() == 0)
            begin
                $error("response with no request outstanding: %p", rsp);
                fault_count++;
            end
            else
            begin
                oldest_rsp = pending_rsp_q.pop_front();
                if (rsp.found !== oldest_rsp.found)
                begin
                    $error("found: expected %0b, got %0b", oldest_rsp.found, rsp.found);
                    fault_count++;
                end
                if (rsp.full_error !== oldest_rsp.full_error)
                begin
                    $error("full_error: expected %0b, got %0b",
                           oldest_rsp.full_error, rsp.full_error);
                    fault_count++;
                end
                if (rsp.count !== oldest_rsp.count)
                begin
                    $error("count: expected %0d, got %0d", oldest_rsp.count, rsp.count);
                    fault_count++;
                end
            end
        end
    end

    // watchdog on cycles with no request or response moving
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        req_t r;
        bit   filling;
        int   rand_count;

        // empty list, extremes and duplicates, then fill past capacity
        dir_rows = '{
            '{OP_SEARCH, 32'sd0,          1'b1, '{1'b0, 1'b0, 5'd0}},
            '{OP_REMOVE, VAL_MAX,         1'b1, '{1'b0, 1'b0, 5'd0}},
            '{OP_IDLE,   -32'sd1,         1'b1, '{1'b0, 1'b0, 5'd0}},
            '{OP_INSERT, VAL_MIN,         1'b1, '{1'b0, 1'b0, 5'd1}},
            '{OP_INSERT, VAL_MAX,         1'b1, '{1'b0, 1'b0, 5'd2}},
            '{OP_INSERT, 32'sd7,          1'b0, '0},
            '{OP_INSERT, 32'sd7,          1'b0, '0},
            '{OP_SEARCH, VAL_MIN,         1'b0, '0},
            '{OP_REMOVE, 32'sd7,          1'b0, '0},
            '{OP_SEARCH, 32'sd7,          1'b0, '0},
            '{OP_REMOVE, 32'sd12345,      1'b0, '0},
            '{OP_IDLE,   32'sd0,          1'b0, '0},
            '{OP_INSERT, -32'sd1,         1'b0, '0},
            '{OP_INSERT, 32'sh5555_5555,  1'b0, '0},
            '{OP_INSERT, 32'shAAAA_AAAA,  1'b0, '0},
            '{OP_INSERT, 32'sd0,          1'b0, '0},
            '{OP_INSERT, 32'sd1,          1'b0, '0},
            '{OP_INSERT, -32'sd2,         1'b0, '0},
            '{OP_INSERT, 32'sh0001_0000,  1'b0, '0},
            '{OP_INSERT, 32'sh4000_0000,  1'b0, '0},
            '{OP_INSERT, 32'shC000_0001,  1'b0, '0},
            '{OP_INSERT, 32'sd42,         1'b0, '0},
            '{OP_INSERT, 32'sh0F0F_0F0F,  1'b0, '0},
            '{OP_INSERT, 32'shF0F0_F0F0,  1'b0, '0},
            '{OP_INSERT, 32'sh1234_5678,  1'b0, '0},
            '{OP_INSERT, 32'sd99,         1'b1, '{1'b0, 1'b1, 5'd16}},
            '{OP_REMOVE, VAL_MIN,         1'b0, '0},
            '{OP_SEARCH, VAL_MIN,         1'b0, '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            r.operation = dir_rows[i].op;
            r.value     = dir_rows[i].value;
            send_req(r, dir_rows[i].typed, dir_rows[i].want);
        end

        filling    = 1'b1;
        rand_count = TOTAL_REQUESTS - DIR_ROWS;
        for (int n = 0; n < rand_count; n++)
        begin
            if (n == rand_count / 3)
            begin
                send_idle_pct  = 63;
                recv_stall_pct = 7;
            end
            else if (n == 2 * rand_count / 3)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            // swing between filling and draining so both full and empty lists recur
            if (n % 64 == 63)
                filling = !filling;
            r.operation = pick_operation(filling);
            r.value     = pick_value();
            send_req(r, 1'b0, '0);
        end
        req_valid <= 1'b0;

        while (pending_rsp_q.size() != 0)
            @(posedge clk);
        repeat (2 * LIST_LATENCY) @(posedge clk);

        if (fault_count == 0 && pending_rsp_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
sv/ovl_pkg.sv
sv/ovl_cell.sv
sv/ordered_value_list_unit.sv
sv/ovl_checker.sv
sim/ordered_value_list_unit_test.sv
